// File: rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // screen geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic        last_of_string;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_data;
        logic        scrolled;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic copy_step;
        logic zero_step;
        logic mark;
        logic load_out;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       last;
        logic       overflow;
        logic       copy_end;
        logic       sweep_end;
        logic       out_free;
    } tcw_stat_t;

endpackage

`default_nettype wire

// File: rtl/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t      cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCOPY = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_MARK  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.zero_step = 1'b1;
                if (stat.sweep_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (stat.opcode)
                    OP_PUT: begin
                        if (stat.overflow) begin
                            state_next = ST_SCOPY;
                        end else if (stat.last) begin
                            state_next = ST_MARK;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_CLEAR: state_next = ST_ZERO;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SCOPY: begin
                cmd.copy_step = 1'b1;
                if (stat.copy_end) begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                cmd.zero_step = 1'b1;
                if (stat.sweep_end) begin
                    if (stat.opcode == OP_PUT && stat.last) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MARK: begin
                cmd.mark   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tcw_dpath.sv
`default_nettype none

module tcw_dpath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tcw_pkg::tcw_cmd_t  cmd,
    output tcw_pkg::tcw_stat_t      stat,
    input  wire tcw_pkg::in_item_t  s_item,
    input  wire logic [7:0]         text_attr,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tcw_pkg::out_item_t      m_item
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    in_item_t    item_reg;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          scrolled_reg;
    logic          m_valid_reg;
    out_item_t     m_item_reg;

    logic          is_put, is_read, printable, newline, in_range;
    logic [AW:0]   moved;
    logic          overflow;
    logic [AW:0]   copy_raddr;
    logic [AW+10:0] idx_wide;
    logic [AW+10:0] cur_wide;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    assign is_put    = (item_reg.opcode == OP_PUT);
    assign is_read   = (item_reg.opcode == OP_READ);
    assign newline   = (item_reg.char_code == CHAR_NEWLINE);
    assign printable = (item_reg.char_code >= CHAR_PRINT_LO)
                    && (item_reg.char_code <= CHAR_PRINT_HI);
    assign in_range  = (32'(item_reg.cell_index) < CELLS);
    assign idx_wide  = {{AW{1'b0}}, item_reg.cell_index};
    assign cur_wide  = {{11{1'b0}}, cursor_reg};

    // cursor after the character, before any scroll
    always_comb begin
        if (newline) begin
            moved = {1'b0, cursor_reg} + (AW+1)'(COLUMNS) - (AW+1)'(col_reg);
        end else begin
            moved = {1'b0, cursor_reg} + (AW+1)'(1);
        end
    end
    assign overflow = (moved >= (AW+1)'(CELLS));

    always_comb begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (cmd.exec && is_put) begin
            if (overflow) begin
                cursor_next = AW'(CELLS - COLUMNS);
                col_next    = '0;
            end else begin
                cursor_next = moved[AW-1:0];
                if (newline || col_reg == CW'(COLUMNS - 1)) begin
                    col_next = '0;
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.exec) begin
            sweep_next = '0;
        end else if (cmd.copy_step || cmd.zero_step) begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    assign copy_raddr = {1'b0, sweep_reg} + (AW+1)'(COLUMNS + 1);

    // store port selection
    always_comb begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = '0;
        if (cmd.exec) begin
            we    = is_put && printable;
            waddr = cursor_reg;
            wdata = {text_attr, item_reg.char_code};
        end else if (cmd.copy_step) begin
            we    = 1'b1;
            wdata = rdata_reg;
        end else if (cmd.zero_step) begin
            we    = 1'b1;
        end else if (cmd.mark) begin
            we    = 1'b1;
            waddr = cursor_reg;
            wdata = {text_attr, 8'h00};
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = copy_raddr[AW-1:0];
        if (cmd.exec) begin
            re    = !is_read || in_range;
            raddr = is_read ? idx_wide[AW-1:0] : AW'(COLUMNS);
        end else if (cmd.copy_step) begin
            re    = !stat.copy_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            col_reg     <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            sweep_reg  <= sweep_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_item;
        end
        if (cmd.exec) begin
            scrolled_reg <= is_put && overflow;
        end
        if (cmd.load_out) begin
            m_item_reg.cursor_pos <= cur_wide[10:0];
            m_item_reg.cell_data  <= (is_read && in_range) ? rdata_reg : 16'h0000;
            m_item_reg.scrolled   <= scrolled_reg;
        end
    end

    assign stat.opcode    = item_reg.opcode;
    assign stat.last      = item_reg.last_of_string;
    assign stat.overflow  = overflow;
    assign stat.copy_end  = (sweep_reg == AW'(CELLS - COLUMNS - 1));
    assign stat.sweep_end = (sweep_reg == AW'(CELLS - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// File: rtl/text_console_writer_unit.sv
// items are taken one at a time: the next is accepted only after the last one's result
// is loaded, which waits while the result channel stalls; a clear or a scroll adds a walk
// through the cell store, and the end of a string adds a blank mark after the character
// reset: synchronous active-low; afterwards a clearing pass zeroes the store while s_ready
// stays low; config writes are taken throughout
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // apb configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcw_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tcw_pkg::DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    // input item channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire tcw_pkg::in_item_t           s_item,
    // result item channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output tcw_pkg::out_item_t               m_item
);
    import tcw_pkg::*;

    logic [7:0] attr_reg;
    logic       reg_hit;
    tcw_cmd_t   cmd;
    tcw_stat_t  stat;

    // one register; the low two address bits are ignored and only pwdata[7:0] is written
    assign reg_hit = (paddr[2] == REG_TEXT_ATTR);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            attr_reg <= pwdata[7:0];
        end
    end

    // read back the attribute, zero elsewhere
    assign prdata = reg_hit ? {{(DATA_W-8){1'b0}}, attr_reg} : '0;

    // sequencer: reset sweep, accept, execute, scroll or clear walk, blank mark, result
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // cell store, cursor, sweep counter and result register
    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_item    (s_item),
        .text_attr (attr_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

// File: rtl/tcw_checker.sv
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire tcw_pkg::out_item_t m_item
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_item.cursor_pos) < CELLS))
        else $error("cursor off screen");

    // a scroll leaves the cursor at the start of the bottom row, no read data
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.scrolled
            |-> (32'(m_item.cursor_pos) == CELLS - COLUMNS) && (m_item.cell_data == 16'h0000))
        else $error("bad cursor after scroll");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
